// ===== design/spq_pkg.sv =====
package spq_pkg;

   // operation codes carried on req_op
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_FIND   = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_TOGGLE = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_POP_RD,
      ST_POP_DAT,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_HEAD_RD,
      ST_HEAD_DAT
   } state_type;

endpackage

// ===== design/sorted_priority_queue_top.sv =====
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+-------------------------------
// request   | req_op, req_value                       | start high, busy low
// response  | rsp_* fields                            | rsp_strobe, one cycle, no stall
// csr write | csr_start_max_priority                  | csr_valid and csr_ready
//
// Entries sit in a circular buffer in ascending order from a base pointer; the front is
// the top entry in max mode and the bottom one in min mode, so a toggle only flips the mode.
// Busy after accept: clear, toggle, spare codes and rejected beats go straight to the head read,
// a pop reads the front first, a query compares entries until a hit or the end, and a push moves
// larger entries up before writing the new value; the strobe follows as a new beat may start.
// Reset clears the count and base pointer and loads max mode; the receiver cannot stall.
module sorted_priority_queue_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [2:0]                            req_op,
   input  logic signed [DATA_WIDTH-1:0]          req_value,
   output logic                                  rsp_strobe,
   output logic signed [DATA_WIDTH-1:0]          rsp_popped_value,
   output logic                                  rsp_found,
   output logic [1:0]                            rsp_status,
   output logic signed [DATA_WIDTH-1:0]          rsp_head_value,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_entry_count,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_max_mode,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_start_max_priority
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(DEPTH);

   spq_pkg::state_type state_ff, state_in;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  start_max_ff;
   logic                  mode_ff, mode_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [DATA_WIDTH-1:0] popped_ff, popped_in;
   logic                  found_ff, found_in;
   logic [1:0]            status_ff, status_in;

   logic                  strobe_ff, strobe_in;
   logic [DATA_WIDTH-1:0] rsp_popped_ff, rsp_popped_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_head_ff, rsp_head_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   logic                  rsp_mode_ff, rsp_mode_in;

   logic                  accept;
   logic [CW-1:0]         log_idx;
   logic [CW-1:0]         front_idx;
   logic [AW:0]           addr_sum;
   logic [AW-1:0]         phys_addr;
   logic                  entry_above;
   logic                  entry_hit;
   logic                  wr_en;
   logic [DATA_WIDTH-1:0] wr_data;

   assign accept    = start && (state_ff == spq_pkg::ST_IDLE);
   assign busy      = (state_ff != spq_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // front position in logical order
   assign front_idx = (mode_ff && (count_ff != '0)) ? (count_ff - CW'(1)) : '0;

   // shared address unit: logical index to buffer slot, wrapping at the depth
   always_comb begin
      addr_sum = {1'b0, base_ff} + {1'b0, log_idx[AW-1:0]};
      if (addr_sum >= DEPTH_SUM) begin
         addr_sum = addr_sum - DEPTH_SUM;
      end
      phys_addr = addr_sum[AW-1:0];
   end

   // shared comparator
   assign entry_above = $signed(rd_data_ff) > $signed(value_ff);
   assign entry_hit   = (rd_data_ff == value_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  spq_pkg::OP_PUSH:
                     state_in = (count_ff == DEPTH_CNT) ? spq_pkg::ST_HEAD_RD
                                                        : spq_pkg::ST_PUSH_RD;
                  spq_pkg::OP_POP:
                     state_in = (count_ff == '0) ? spq_pkg::ST_HEAD_RD
                                                 : spq_pkg::ST_POP_RD;
                  spq_pkg::OP_FIND: state_in = spq_pkg::ST_FIND_RD;
                  default:          state_in = spq_pkg::ST_HEAD_RD;
               endcase
            end
         end
         spq_pkg::ST_PUSH_RD:
            state_in = (idx_ff == '0) ? spq_pkg::ST_HEAD_RD : spq_pkg::ST_PUSH_CMP;
         spq_pkg::ST_PUSH_CMP:
            state_in = entry_above ? spq_pkg::ST_PUSH_RD : spq_pkg::ST_HEAD_RD;
         spq_pkg::ST_POP_RD:   state_in = spq_pkg::ST_POP_DAT;
         spq_pkg::ST_POP_DAT:  state_in = spq_pkg::ST_HEAD_RD;
         spq_pkg::ST_FIND_RD:
            state_in = (idx_ff == count_ff) ? spq_pkg::ST_HEAD_RD : spq_pkg::ST_FIND_CMP;
         spq_pkg::ST_FIND_CMP:
            state_in = entry_hit ? spq_pkg::ST_HEAD_RD : spq_pkg::ST_FIND_RD;
         spq_pkg::ST_HEAD_RD:  state_in = spq_pkg::ST_HEAD_DAT;
         spq_pkg::ST_HEAD_DAT: state_in = spq_pkg::ST_IDLE;
         default:              state_in = spq_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in       = mode_ff;
      count_in      = count_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      popped_in     = popped_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      strobe_in     = 1'b0;
      rsp_popped_in = rsp_popped_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_mode_in   = rsp_mode_ff;
      log_idx       = '0;
      wr_en         = 1'b0;
      wr_data       = value_ff;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (accept) begin
               value_in  = req_value;
               popped_in = '0;
               found_in  = 1'b0;
               status_in = spq_pkg::STATUS_OK;
               idx_in    = '0;
               case (req_op)
                  spq_pkg::OP_PUSH: begin
                     idx_in = count_ff;
                     if (count_ff == DEPTH_CNT) begin
                        status_in = spq_pkg::STATUS_FULL;
                     end
                  end
                  spq_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                     end
                  end
                  spq_pkg::OP_CLEAR: begin
                     count_in = '0;
                     base_in  = '0;
                     mode_in  = start_max_ff;
                  end
                  spq_pkg::OP_TOGGLE: begin
                     mode_in = ~mode_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // insert at the bottom, or fetch the entry below the gap
         spq_pkg::ST_PUSH_RD: begin
            if (idx_ff == '0) begin
               log_idx  = '0;
               wr_en    = 1'b1;
               wr_data  = value_ff;
               count_in = count_ff + CW'(1);
            end else begin
               log_idx = idx_ff - CW'(1);
            end
         end
         // move the larger entry up, or drop the new value into the gap
         spq_pkg::ST_PUSH_CMP: begin
            log_idx = idx_ff;
            wr_en   = 1'b1;
            if (entry_above) begin
               wr_data = rd_data_ff;
               idx_in  = idx_ff - CW'(1);
            end else begin
               wr_data  = value_ff;
               count_in = count_ff + CW'(1);
            end
         end
         spq_pkg::ST_POP_RD: begin
            log_idx = front_idx;
         end
         // in min mode the base moves up one slot
         spq_pkg::ST_POP_DAT: begin
            log_idx   = CW'(1);
            popped_in = rd_data_ff;
            count_in  = count_ff - CW'(1);
            if (!mode_ff) begin
               base_in = phys_addr;
            end
         end
         spq_pkg::ST_FIND_RD: begin
            if (idx_ff != count_ff) begin
               log_idx = idx_ff;
            end
         end
         spq_pkg::ST_FIND_CMP: begin
            if (entry_hit) begin
               found_in = 1'b1;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         spq_pkg::ST_HEAD_RD: begin
            log_idx = front_idx;
         end
         spq_pkg::ST_HEAD_DAT: begin
            strobe_in     = 1'b1;
            rsp_popped_in = popped_ff;
            rsp_found_in  = found_ff;
            rsp_status_in = status_ff;
            rsp_head_in   = (count_ff == '0) ? '0 : rd_data_ff;
            rsp_count_in  = count_ff;
            rsp_mode_in   = mode_ff;
         end
         default: begin
         end
      endcase
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[phys_addr] <= wr_data;
      end
      rd_data_ff <= mem[phys_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         start_max_ff <= 1'b1;
         mode_ff      <= 1'b1;
         count_ff     <= '0;
         base_ff      <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         base_ff   <= base_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            start_max_ff <= csr_start_max_priority;
         end
      end
   end

   // working and response registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      popped_ff     <= popped_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_mode_ff   <= rsp_mode_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_head_value   = rsp_head_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_is_empty     = (rsp_count_ff == '0);
   assign rsp_max_mode     = rsp_mode_ff;

endmodule

// ===== sim/tb_sorted_priority_queue_top.sv =====
`timescale 1ns / 100ps

// one queue response, field for field as it leaves the block
typedef struct {
   logic [2:0]         req_op;
   logic signed [31:0] req_value;
   logic signed [31:0] popped;
   logic               found;
   logic [1:0]         status;
   logic signed [31:0] head;
   logic [4:0]         count;
   logic               empty;
   logic               mode;
} queue_rsp_type;

class queue_scoreboard_type;
   localparam int SLOTS = 16;

   // shadow of the sorted store, front first
   logic signed [31:0] held [SLOTS];
   int unsigned        held_n;
   logic               mode_max;
   logic               start_max;
   queue_rsp_type      awaited_rsp [$];
   int unsigned        errors;
   int unsigned        checked;
   int unsigned        op_seen [8];
   int unsigned        full_rejects;
   int unsigned        empty_pops;
   int unsigned        peak_fill;

   function new();
      held_n       = 0;
      start_max    = 1'b1;
      mode_max     = 1'b1;
      errors       = 0;
      checked      = 0;
      full_rejects = 0;
      empty_pops   = 0;
      peak_fill    = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (held[i]) held[i] = '0;
   endfunction

   function int unsigned pending();
      return awaited_rsp.size();
   endfunction

   function void note_config(logic max_first);
      start_max = max_first;
   endfunction

   // strict ordering under the current mode
   function bit stands_ahead(logic signed [31:0] a, logic signed [31:0] b);
      if (mode_max) return a > b;
      return a < b;
   endfunction

   // apply one queue operation to the shadow and queue up the response it implies
   function void note_request(logic [2:0] op, logic signed [31:0] value);
      queue_rsp_type      want;
      int unsigned        i;
      int unsigned        j;
      logic signed [31:0] swap;
      want.req_op    = op;
      want.req_value = value;
      want.popped    = '0;
      want.found     = 1'b0;
      want.status    = spq_pkg::STATUS_OK;
      op_seen[op]++;
      case (op)
         spq_pkg::OP_PUSH: begin
            if (held_n >= SLOTS) begin
               want.status = spq_pkg::STATUS_FULL;
               full_rejects++;
            end else begin
               // a new value goes ahead of entries equal to it
               i = 0;
               while (i < held_n && stands_ahead(held[i], value)) i++;
               for (j = held_n; j > i; j--) held[j] = held[j-1];
               held[i] = value;
               held_n++;
            end
         end
         spq_pkg::OP_POP: begin
            if (held_n == 0) begin
               want.status = spq_pkg::STATUS_EMPTY;
               empty_pops++;
            end else begin
               want.popped = held[0];
               for (j = 1; j < held_n; j++) held[j-1] = held[j];
               held_n--;
            end
         end
         spq_pkg::OP_FIND: begin
            for (i = 0; i < held_n; i++)
               if (held[i] == value) want.found = 1'b1;
         end
         spq_pkg::OP_CLEAR: begin
            held_n   = 0;
            mode_max = start_max;
         end
         spq_pkg::OP_TOGGLE: begin
            // reversal keeps the front in line with the new mode
            mode_max = ~mode_max;
            if (held_n >= 2) begin
               i = 0;
               j = held_n - 1;
               while (i < j) begin
                  swap    = held[i];
                  held[i] = held[j];
                  held[j] = swap;
                  i++;
                  j--;
               end
            end
         end
         default: ;
      endcase
      if (held_n > peak_fill) peak_fill = held_n;
      want.head  = (held_n != 0) ? held[0] : '0;
      want.count = held_n[4:0];
      want.empty = (held_n == 0);
      want.mode  = mode_max;
      awaited_rsp.push_back(want);
   endfunction

   task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
   endtask

   // compare one response beat against the oldest awaited one
   task check_response(queue_rsp_type got);
      queue_rsp_type want;
      string         tag;
      if (awaited_rsp.size() == 0) begin
         report_mismatch("response beat with nothing outstanding");
         return;
      end
      want = awaited_rsp.pop_front();
      checked++;
      tag = $sformatf("op %0d value %0d:", want.req_op, want.req_value);
      if (got.popped !== want.popped)
         report_mismatch($sformatf("%s popped_value %0d, want %0d", tag, got.popped,
                                   want.popped));
      if (got.found !== want.found)
         report_mismatch($sformatf("%s found %b, want %b", tag, got.found, want.found));
      if (got.status !== want.status)
         report_mismatch($sformatf("%s status %0d, want %0d", tag, got.status, want.status));
      if (got.head !== want.head)
         report_mismatch($sformatf("%s head_value %0d, want %0d", tag, got.head, want.head));
      if (got.count !== want.count)
         report_mismatch($sformatf("%s entry_count %0d, want %0d", tag, got.count,
                                   want.count));
      if (got.empty !== want.empty)
         report_mismatch($sformatf("%s is_empty %b, want %b", tag, got.empty, want.empty));
      if (got.mode !== want.mode)
         report_mismatch($sformatf("%s max_mode %b, want %b", tag, got.mode, want.mode));
   endtask
endclass

module tb_sorted_priority_queue_top;
   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 155;

   // op codes the block leaves unused
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [2:0]                   req_op;
   logic signed [DATA_WIDTH-1:0] req_value;
   logic                         rsp_strobe;
   logic signed [DATA_WIDTH-1:0] rsp_popped_value;
   logic                         rsp_found;
   logic [1:0]                   rsp_status;
   logic signed [DATA_WIDTH-1:0] rsp_head_value;
   logic [4:0]                   rsp_entry_count;
   logic                         rsp_is_empty;
   logic                         rsp_max_mode;
   logic                         csr_valid;
   logic                         csr_ready;
   logic                         csr_start_max_priority;

   queue_scoreboard_type sb;
   int unsigned          items_sent;
   int unsigned          csr_writes;
   int unsigned          burst_left;
   int unsigned          quiet_cycles;
   bit                   gaps_on;

   sorted_priority_queue_top #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_op                 (req_op),
      .req_value              (req_value),
      .rsp_strobe             (rsp_strobe),
      .rsp_popped_value       (rsp_popped_value),
      .rsp_found              (rsp_found),
      .rsp_status             (rsp_status),
      .rsp_head_value         (rsp_head_value),
      .rsp_entry_count        (rsp_entry_count),
      .rsp_is_empty           (rsp_is_empty),
      .rsp_max_mode           (rsp_max_mode),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_start_max_priority (csr_start_max_priority)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      queue_rsp_type got;
      if (!reset && rsp_strobe) begin
         got.req_op    = '0;
         got.req_value = '0;
         got.popped    = rsp_popped_value;
         got.found     = rsp_found;
         got.status    = rsp_status;
         got.head      = rsp_head_value;
         got.count     = rsp_entry_count;
         got.empty     = rsp_is_empty;
         got.mode      = rsp_max_mode;
         sb.check_response(got);
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d responses outstanding",
                  QUIET_LIMIT, sb.pending());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // value mix: full range, a narrow band for duplicates, a middle band, and the extremes
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2, 3: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
         4: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
      endcase
   endfunction

   // while entries are held, half the lookups take a value that is held
   function automatic logic signed [31:0] lookup_value();
      if (sb.held_n > 0 && $urandom_range(0, 1) == 1)
         return sb.held[$urandom_range(0, sb.held_n - 1)];
      return pick_value();
   endfunction

   // one request beat; the sender runs in bursts separated by random gaps when gaps are on
   task automatic send_op(input logic [2:0] op, input logic signed [31:0] value);
      if (burst_left == 0) begin
         if (gaps_on) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      start     = 1'b1;
      req_op    = op;
      req_value = value;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(op, value);
      items_sent++;
      @(negedge clock);
   endtask

   // hold the sender off until every outstanding response is back
   task automatic wait_drained();
      start = 1'b0;
      while (sb.pending() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_start_mode(input logic max_first);
      csr_valid              = 1'b1;
      csr_start_max_priority = max_first;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_config(max_first);
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // push a run of values with the odd lookup or toggle, then pop none, part, all or a little more than all of it
   task automatic fill_and_drain();
      int unsigned fill_n;
      int unsigned drain_n;
      fill_n = $urandom_range(1, 19);
      repeat (fill_n) begin
         send_op(spq_pkg::OP_PUSH, pick_value());
         case ($urandom_range(0, 7))
            0: send_op(spq_pkg::OP_FIND, lookup_value());
            1: send_op(spq_pkg::OP_TOGGLE, $urandom);
            default: ;
         endcase
      end
      drain_n = $urandom_range(0, sb.held_n + 2);
      repeat (drain_n) begin
         send_op(spq_pkg::OP_POP, $urandom);
         if ($urandom_range(0, 5) == 0) send_op(spq_pkg::OP_FIND, lookup_value());
      end
   endtask

   initial begin
      sb                     = new();
      reset                  = 1'b1;
      start                  = 1'b0;
      req_op                 = spq_pkg::OP_PUSH;
      req_value              = '0;
      csr_valid              = 1'b0;
      csr_start_max_priority = 1'b1;
      items_sent             = 0;
      csr_writes             = 0;
      burst_left             = 0;
      gaps_on                = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, duplicates, lookups, reversal, empty and spare codes
      send_op(spq_pkg::OP_PUSH, 32'sh7fff_ffff);
      send_op(spq_pkg::OP_PUSH, 32'sh8000_0000);
      send_op(spq_pkg::OP_PUSH, 32'sd0);
      send_op(spq_pkg::OP_PUSH, 32'sd0);
      send_op(spq_pkg::OP_PUSH, -32'sd1);
      send_op(spq_pkg::OP_FIND, 32'sd0);
      send_op(spq_pkg::OP_FIND, 32'sd1);
      send_op(spq_pkg::OP_TOGGLE, 32'sd0);
      send_op(spq_pkg::OP_POP, 32'sd0);
      send_op(spq_pkg::OP_POP, 32'sd0);
      send_op(OP_SPARE_A, 32'sh7fff_ffff);
      send_op(OP_SPARE_B, 32'sh8000_0000);
      send_op(OP_SPARE_C, -32'sd1);
      send_op(spq_pkg::OP_TOGGLE, 32'sd0);
      send_op(spq_pkg::OP_POP, 32'sd0);
      send_op(spq_pkg::OP_POP, 32'sd0);
      send_op(spq_pkg::OP_POP, 32'sd0);
      send_op(spq_pkg::OP_POP, 32'sd0);
      send_op(spq_pkg::OP_TOGGLE, 32'sd0);
      send_op(spq_pkg::OP_PUSH, 32'sd5);
      send_op(spq_pkg::OP_TOGGLE, 32'sd0);
      send_op(spq_pkg::OP_CLEAR, 32'sd0);
      wait_drained();

      // random phases, each under its own start mode
      for (int phase = 0; phase < PHASES; phase++) begin
         gaps_on = (phase % 4 != 1);
         if (phase == 0)
            write_start_mode(1'b0);
         else if (phase == 1)
            write_start_mode(1'b1);
         else
            write_start_mode(1'($urandom_range(0, 1)));
         if (phase < 2 || $urandom_range(0, 1) == 1) send_op(spq_pkg::OP_CLEAR, $urandom);
         while (items_sent < 25 + (phase + 1) * PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               6, 7: repeat (8) send_op(3'($urandom_range(0, 7)), pick_value());
               8: send_op(spq_pkg::OP_CLEAR, $urandom);
               9: repeat ($urandom_range(1, 3)) send_op(spq_pkg::OP_TOGGLE, $urandom);
               default: fill_and_drain();
            endcase
         end
         wait_drained();
      end

      // let any stray response beat show up
      start = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run covered %0d requests: push %0d, pop %0d, find %0d, clear %0d, toggle %0d",
               items_sent, sb.op_seen[spq_pkg::OP_PUSH], sb.op_seen[spq_pkg::OP_POP],
               sb.op_seen[spq_pkg::OP_FIND], sb.op_seen[spq_pkg::OP_CLEAR],
               sb.op_seen[spq_pkg::OP_TOGGLE]);
      $display("%0d responses checked, %0d full rejects, %0d empty pops, %s",
               sb.checked, sb.full_rejects, sb.empty_pops,
               $sformatf("peak fill %0d, %0d csr writes", sb.peak_fill, csr_writes));
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/spq_pkg.sv
design/sorted_priority_queue_top.sv
sim/tb_sorted_priority_queue_top.sv
